// File: rtl/bts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

  // Field widths
  localparam int COLOR_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = 24;
  localparam int POS_W      = 8;
  localparam int DIM_W      = 9;
  localparam int ADDR_W     = 2 * POS_W;
  localparam int ACC_W      = COLOR_W + FRAC_W;
  localparam int CNT_W      = 4;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 3 * COLOR_W;

  localparam logic [DIM_W-1:0]   MAX_DIM   = 9'd256;
  localparam logic [COLOR_W-1:0] COLOR_ONE = 16'h0100;

  // Sequencer step limits
  localparam logic [CNT_W-1:0] READ_LAST  = 4'd4;
  localparam logic [CNT_W-1:0] BLEND_LAST = 4'd9;

  // One texel, red in the low bits
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } texel_t;

  typedef enum logic [1:0] {
    ST_SAMPLE_OK  = 2'd0,
    ST_WR_DONE    = 2'd1,
    ST_WR_IGNORED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    FILT_POINT    = 1'b0,
    FILT_BILINEAR = 1'b1
  } filter_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCALE_X,
    S_SCALE_Y,
    S_LATCH_Y,
    S_READ,
    S_BLEND,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bts_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply-add: acc = (a << FRAC_W) + w * (b - a) + optional half LSB.
// With a = 0 it gives the plain product w * b.
module bts_mac import bts_pkg::*; (
  input  logic               clk,
  input  logic [COLOR_W-1:0] op_a,
  input  logic [COLOR_W-1:0] op_b,
  input  logic [FRAC_W-1:0]  op_w,
  input  logic               rnd,
  output logic [ACC_W-1:0]   acc_r
);

  localparam int SUM_W = ACC_W + 2;

  logic signed [COLOR_W:0]  diff;
  logic signed [SUM_W-1:0]  prod;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  half;
  logic signed [SUM_W-1:0]  sum;
  logic [ACC_W-1:0]         acc_nxt;

  assign diff = $signed({1'b0, op_b}) - $signed({1'b0, op_a});
  assign prod = SUM_W'($signed({1'b0, op_w})) * SUM_W'(diff);
  assign base = $signed({2'b00, op_a, {FRAC_W{1'b0}}});
  assign half = $signed({{(SUM_W-FRAC_W){1'b0}}, rnd, {(FRAC_W-1){1'b0}}});

  // result is a convex blend, never negative and below 2^ACC_W
  assign sum     = base + prod + half;
  assign acc_nxt = sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/bts_texmem.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port texel store, row-major, registered read
module bts_texmem import bts_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  texel_t            wdata,
  output texel_t            rdata_r
);

  texel_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bilinear_texture_sampler.sv
`timescale 1ns / 1ps
`default_nettype none

// Requests are handled one at a time: a new request is taken only in the idle state, once
// the previous result has been loaded into the output register. Bilinear sampling shares one
// multiply-add unit (2 scalings + 9 blend steps) and one texel memory port (4 reads).
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) clears control and both size registers; the texel store
// is not cleared and needs no clearing pass.
module bilinear_texture_sampler import bts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // texel_col, texel_row, red_in, green_in, blue_in, u_coord, v_coord, filter_mode
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]            out_tuser,
  // configuration
  input  logic                  cfg_wen,
  input  logic                  cfg_addr,
  input  logic [DIM_W-1:0]      cfg_wdata
);

  // Request unpacking
  logic [POS_W-1:0]   in_texel_col;
  logic [POS_W-1:0]   in_texel_row;
  texel_t             in_texel;
  logic [COORD_W-1:0] in_u_coord;
  logic [COORD_W-1:0] in_v_coord;
  filter_t            in_filter_mode;
  op_t                in_op;

  assign in_texel_col   = in_tdata[7:0];
  assign in_texel_row   = in_tdata[15:8];
  assign in_texel.red   = in_tdata[31:16];
  assign in_texel.green = in_tdata[47:32];
  assign in_texel.blue  = in_tdata[63:48];
  assign in_u_coord     = in_tdata[87:64];
  assign in_v_coord     = in_tdata[111:88];
  assign in_filter_mode = filter_t'(in_tdata[112]);
  assign in_op          = op_t'(in_tuser);

  // Control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0] width_r, height_r;
  logic             out_tvalid_r;

  // Request and working registers
  logic [POS_W-1:0]  col_r, row_r;
  texel_t            wtex_r;
  logic [FRAC_W-1:0] fu_r, fv_r;
  filter_t           filter_r;
  logic [POS_W-1:0]  x0_r, y0_r;
  logic [FRAC_W-1:0] wx_r, wy_r;
  texel_t            tex_r [4];
  logic [COLOR_W-1:0] blend_r [9];
  texel_t            fin_r;
  status_t           fin_st_r;
  texel_t            out_tex_r;
  status_t           out_st_r;

  // Shared unit and memory hookup
  logic [COLOR_W-1:0] mac_a, mac_b;
  logic [FRAC_W-1:0]  mac_w;
  logic               mac_rnd;
  logic [ACC_W-1:0]   acc_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  texel_t             rdata_r;

  logic               in_accept;
  logic               empty_tex;
  logic               wr_in_range;
  logic               out_load;
  logic [DIM_W-1:0]   x_inc, y_inc, width_m1, height_m1, cfg_dim;
  logic [POS_W-1:0]   x1, y1;
  logic [1:0]         tex_cap;
  logic [CNT_W-1:0]   blend_cap;
  logic [COLOR_W-1:0] acc_round;

  assign in_accept   = in_tvalid && in_tready;
  assign empty_tex   = (width_r == '0) || (height_r == '0);
  assign wr_in_range = ({1'b0, col_r} < width_r) && ({1'b0, row_r} < height_r);
  assign acc_round   = acc_r[ACC_W-1:FRAC_W];
  assign tex_cap     = cnt_r[1:0] - 2'd1;
  assign blend_cap   = cnt_r - 4'd1;

  // Neighbor column and row, clamped to the last texel
  assign x_inc     = {1'b0, x0_r} + 9'd1;
  assign y_inc     = {1'b0, y0_r} + 9'd1;
  assign width_m1  = width_r - 9'd1;
  assign height_m1 = height_r - 9'd1;
  assign x1 = (x_inc >= width_r)  ? width_m1[POS_W-1:0]  : x_inc[POS_W-1:0];
  assign y1 = (y_inc >= height_r) ? height_m1[POS_W-1:0] : y_inc[POS_W-1:0];

  assign cfg_dim = (cfg_wdata > MAX_DIM) ? MAX_DIM : cfg_wdata;

  bts_mac u_mac (
    .clk   (clk),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .op_w  (mac_w),
    .rnd   (mac_rnd),
    .acc_r (acc_r)
  );

  bts_texmem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (wtex_r),
    .rdata_r (rdata_r)
  );

  // Sequencer: next state and unit control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {y0_r, x0_r};
    mac_a     = '0;
    mac_b     = '0;
    mac_w     = '0;
    mac_rnd   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_WRITE) begin
            state_nxt = S_WRITE;
          end else if (empty_tex) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCALE_X;
          end
        end
      end
      S_WRITE: begin
        mem_we    = wr_in_range;
        mem_addr  = {row_r, col_r};
        state_nxt = S_DONE;
      end
      S_SCALE_X: begin
        mac_b     = COLOR_W'(width_r);
        mac_w     = fu_r;
        state_nxt = S_SCALE_Y;
      end
      S_SCALE_Y: begin
        mac_b     = COLOR_W'(height_r);
        mac_w     = fv_r;
        state_nxt = S_LATCH_Y;
      end
      S_LATCH_Y: begin
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        unique case (cnt_r[1:0])
          2'd0:    mem_addr = {y0_r, x0_r};
          2'd1:    mem_addr = {y0_r, x1};
          2'd2:    mem_addr = {y1, x0_r};
          default: mem_addr = {y1, x1};
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (filter_r == FILT_POINT && cnt_r != '0) begin
          state_nxt = S_DONE;
        end else if (cnt_r == READ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        mac_rnd = 1'b1;
        unique case (cnt_r)
          4'd0: begin mac_a = tex_r[0].red;   mac_b = tex_r[1].red;   mac_w = wx_r; end
          4'd1: begin mac_a = tex_r[0].green; mac_b = tex_r[1].green; mac_w = wx_r; end
          4'd2: begin mac_a = tex_r[0].blue;  mac_b = tex_r[1].blue;  mac_w = wx_r; end
          4'd3: begin mac_a = tex_r[2].red;   mac_b = tex_r[3].red;   mac_w = wx_r; end
          4'd4: begin mac_a = tex_r[2].green; mac_b = tex_r[3].green; mac_w = wx_r; end
          4'd5: begin mac_a = tex_r[2].blue;  mac_b = tex_r[3].blue;  mac_w = wx_r; end
          4'd6: begin mac_a = blend_r[0];     mac_b = blend_r[3];     mac_w = wy_r; end
          4'd7: begin mac_a = blend_r[1];     mac_b = blend_r[4];     mac_w = wy_r; end
          4'd8: begin mac_a = blend_r[2];     mac_b = blend_r[5];     mac_w = wy_r; end
          default: mac_rnd = 1'b1;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == BLEND_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      width_r      <= '0;
      height_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wen) begin
        if (cfg_idx_t'(cfg_addr) == CFG_WIDTH) begin
          width_r <= cfg_dim;
        end else begin
          height_r <= cfg_dim;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      col_r    <= in_texel_col;
      row_r    <= in_texel_row;
      wtex_r   <= in_texel;
      fu_r     <= in_u_coord[FRAC_W-1:0];
      fv_r     <= in_v_coord[FRAC_W-1:0];
      filter_r <= in_filter_mode;
      // empty texture answers magenta
      fin_r.red   <= COLOR_ONE;
      fin_r.green <= '0;
      fin_r.blue  <= COLOR_ONE;
      fin_st_r    <= ST_EMPTY;
    end

    unique case (state_r)
      S_WRITE: begin
        fin_r    <= '0;
        fin_st_r <= wr_in_range ? ST_WR_DONE : ST_WR_IGNORED;
      end
      S_SCALE_Y: begin
        x0_r <= acc_r[FRAC_W+POS_W-1:FRAC_W];
        wx_r <= acc_r[FRAC_W-1:0];
      end
      S_LATCH_Y: begin
        y0_r <= acc_r[FRAC_W+POS_W-1:FRAC_W];
        wy_r <= acc_r[FRAC_W-1:0];
      end
      S_READ: begin
        if (cnt_r != '0) begin
          tex_r[tex_cap] <= rdata_r;
          if (filter_r == FILT_POINT) begin
            fin_r    <= rdata_r;
            fin_st_r <= ST_SAMPLE_OK;
          end
        end
      end
      S_BLEND: begin
        if (cnt_r != '0) begin
          blend_r[blend_cap] <= acc_round;
        end
        if (cnt_r == BLEND_LAST) begin
          fin_r.red   <= blend_r[6];
          fin_r.green <= blend_r[7];
          fin_r.blue  <= acc_round;
          fin_st_r    <= ST_SAMPLE_OK;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_tex_r <= fin_r;
      out_st_r  <= fin_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tex_r;
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire
